// ===== design/bec_pkg.sv =====
// shared constants and types of the bipolar envelope compressor
// no dependencies; compiled first
`default_nettype none
package bec_pkg;

  // default widths of sample and envelope words
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int ENVELOPE_BITS_DEF = 40;

  // golden-ratio blend weights, Q0.24
  localparam logic [23:0] PHI_Q24  = 24'd10368890;
  localparam logic [23:0] PHIC_Q24 = 24'd6408326;
  localparam int unsigned ONE_Q24  = 32'd16777216;

  // configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_ENGAGE      = 3'd0,
    REG_INPUT_GAIN  = 3'd1,
    REG_SMOOTH_RATE = 3'd2,
    REG_MAKEUP      = 3'd3,
    REG_OUTPUT_GAIN = 3'd4
  } reg_idx_e;

  // register reset values
  localparam logic        ENGAGE_RST      = 1'b0;
  localparam logic [15:0] INPUT_GAIN_RST  = 16'd1024;
  localparam logic [20:0] SMOOTH_RATE_RST = 21'd6711;
  localparam logic [16:0] MAKEUP_RST      = 17'd65536;
  localparam logic [15:0] OUTPUT_GAIN_RST = 16'd16384;

endpackage
`default_nettype wire

// ===== design/bec_frame_in_if.sv =====
// stream channel that carries one stereo input frame
// depends on bec_pkg for the default sample width
`default_nettype none
interface bec_frame_in_if #(
  parameter int SAMPLE_BITS = bec_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

// ===== design/bec_frame_out_if.sv =====
// stream channel that carries one stereo result frame
// depends on bec_pkg for the default sample width
`default_nettype none
interface bec_frame_out_if #(
  parameter int SAMPLE_BITS = bec_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

// ===== design/bipolar_envelope_compressor.sv =====
// top level of the stereo bipolar envelope compressor
// depends on bec_pkg, bec_frame_in_if and bec_frame_out_if
`default_nettype none

// One stereo frame is taken at a time. Disengaged, a frame passes through from
// ST_IDLE straight to ST_DONE. Engaged, both channels run through one shared
// shift-and-add multiplier that retires one multiplier bit per cycle, and one
// restoring divider that makes one quotient bit per cycle of a 49-bit quotient
// for the inverse square of the envelope. Results wait in an output register, so
// the next frame is taken while the previous result is still unread. Envelope and
// control gains are kept per channel and per frame parity; parity toggles on every
// frame.
module bipolar_envelope_compressor #(
  parameter int SAMPLE_BITS   = bec_pkg::SAMPLE_BITS_DEF,
  parameter int ENVELOPE_BITS = bec_pkg::ENVELOPE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  bec_frame_in_if.sink                             frame_i,
  bec_frame_out_if.source                          frame_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bec_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [bec_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic      [bec_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                     pready
);
  import bec_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int EW   = ENVELOPE_BITS;
  localparam int GB   = S + 6;          // gained sample width
  localparam int BW   = GB + 26;        // blend accumulator width
  localparam int MW   = EW + 2;         // mixed gain width
  localparam int AW   = S + 8;          // scaled magnitude width
  localparam int QW   = 49;             // 2^48 / env quotient width
  localparam int SQS  = 2 * S - 26;     // square shift down to Q.24
  localparam int WM0  = (MW > AW) ? MW : AW;
  localparam int WM   = (WM0 > QW) ? WM0 : QW;
  localparam int PW   = 2 * WM;         // product width

  localparam logic [GB+2:0] SONE3  = {{(GB+3-S){1'b0}}, 1'b1, {(S-1){1'b0}}};
  localparam logic [GB-2:0] SONE_H = {{(GB-1-S){1'b0}}, 1'b1, {(S-1){1'b0}}};
  localparam logic [S-1:0]  SONE_S = {1'b1, {(S-1){1'b0}}};
  localparam logic [EW-1:0] ENV_ONE = EW'(ONE_Q24);
  localparam logic [5:0]    DIV_STEPS = 6'(QW);

  typedef enum logic [4:0] {
    ST_IDLE, ST_G, ST_B1, ST_B2, ST_SQP, ST_SQN, ST_SM1, ST_SM2,
    ST_DIVS, ST_DIV, ST_INV, ST_MIX1, ST_MIX2, ST_GAIN1, ST_GAIN2,
    ST_OUTM, ST_DONE
  } state_e;

  typedef enum logic [1:0] {SEL_TP, SEL_TN, SEL_CP, SEL_CN} sel_e;

  // configuration registers
  logic        engage_q;
  logic [15:0] input_gain_q;
  logic [20:0] rate_q;
  logic [16:0] makeup_q;
  logic [15:0] out_gain_q;

  // sequencer and working registers
  state_e          state_q;
  sel_e            sel_q;
  logic            ch_q;
  logic            parity_q;
  logic            issued_q;
  logic [S-1:0]    x_q [2];
  logic [S-1:0]    res_q [2];
  logic [GB-1:0]   g_q;
  logic [GB-1:0]   prev_q [2];
  logic [BW-1:0]   bacc_q;
  logic [GB-1:0]   up_q, un_q;
  logic [S-1:0]    op_q, on_q;
  logic [EW-1:0]   fresh_q, sm_q;
  logic [MW-1:0]   m_q;
  logic [32:0]     mo_q;
  logic [AW-1:0]   a_q;
  logic [EW-1:0]   tpos_q [4], tneg_q [4], cpos_q [4], cneg_q [4];

  // shared bit-serial multiplier
  logic [PW-1:0]   mul_a_q, mul_p_q;
  logic [WM-1:0]   mul_b_q;

  // restoring divider
  logic [EW-1:0]   div_d_q, div_rem_q;
  logic [QW-1:0]   div_q_q;
  logic [5:0]      div_cnt_q;

  // output register
  logic            out_valid_q;
  logic [S-1:0]    out_l_q, out_r_q;

  // combinational helpers
  logic [1:0]      idx;
  logic [S-1:0]    x_cur, x_mag;
  logic            x_neg, g_neg, g_pos, prev_neg, mul_done;
  logic [S+15:0]   gx_m;
  logic [S+16:0]   gx_r;
  logic [GB-1:0]   g_abs, g_new, g_mag, prev_mag;
  logic [BW-1:0]   term, bsum;
  logic [GB+1:0]   b_s;
  logic [GB+2:0]   pp, nn;
  logic [GB-1:0]   up_n, un_n;
  logic [GB-2:0]   hp, hn;
  logic [S-1:0]    op_n, on_n;
  logic [EW-1:0]   cap24, capsq, old_cur, env_sel, sm_new;
  logic [EW:0]     sm_sum;
  logic [24:0]     keep;
  logic [S-1:0]    yv, ylim, ysat, yout;
  logic            ybig;
  logic [EW:0]     rem_sh;
  logic [EW-1:0]   mix_term;
  logic            cfg_wr;

  assign idx      = {parity_q, ch_q};
  assign x_cur    = x_q[ch_q];
  assign x_neg    = x_cur[S-1];
  assign x_mag    = x_neg ? (S)'(-x_cur) : x_cur;
  assign mul_done = issued_q && (mul_b_q == '0);

  // drive gain with floor toward minus infinity
  assign gx_m  = mul_p_q[S+15:0];
  assign gx_r  = {1'b0, gx_m} + (S+17)'(1023);
  assign g_abs = x_neg ? gx_r[S+15:10] : gx_m[S+15:10];
  assign g_new = x_neg ? (GB)'(-g_abs) : g_abs;

  assign g_neg    = g_q[GB-1];
  assign g_pos    = !g_q[GB-1] && (g_q != '0);
  assign g_mag    = g_neg ? (GB)'(-g_q) : g_q;
  assign prev_neg = prev_q[ch_q][GB-1];
  assign prev_mag = prev_neg ? (GB)'(-prev_q[ch_q]) : prev_q[ch_q];

  // signed blend terms
  assign term = (state_q == ST_B1) ?
                (g_neg ? (BW)'(-mul_p_q[BW-1:0]) : mul_p_q[BW-1:0]) :
                (prev_neg ? (BW)'(-mul_p_q[BW-1:0]) : mul_p_q[BW-1:0]);
  assign bsum = bacc_q + term;
  assign b_s  = bsum[BW-1:24];
  assign pp   = {b_s[GB+1], b_s} + SONE3;
  assign nn   = SONE3 - {b_s[GB+1], b_s};
  assign up_n = pp[GB+2] ? '0 : pp[GB-1:0];
  assign un_n = nn[GB+2] ? '0 : nn[GB-1:0];
  assign hp   = up_n[GB-1:1];
  assign hn   = un_n[GB-1:1];
  assign op_n = (hp > SONE_H) ? SONE_S : hp[S-1:0];
  assign on_n = (hn > SONE_H) ? SONE_S : hn[S-1:0];

  // product extracts; cap24 and capsq saturate
  assign cap24    = (|mul_p_q[PW-1:EW+24]) ? '1 : mul_p_q[EW+23:24];
  assign capsq    = (|mul_p_q[PW-1:EW+SQS]) ? '1 : mul_p_q[EW+SQS-1:SQS];
  assign mix_term = mul_p_q[EW+S-2:S-1];

  // one-pole smoothing operands
  assign keep = 25'(ONE_Q24) - 25'(rate_q);
  always_comb begin
    case (sel_q)
      SEL_TP:  old_cur = tpos_q[idx];
      SEL_TN:  old_cur = tneg_q[idx];
      SEL_CP:  old_cur = cpos_q[idx];
      SEL_CN:  old_cur = cneg_q[idx];
      default: old_cur = tpos_q[idx];
    endcase
  end
  assign sm_sum  = {1'b0, sm_q} + {1'b0, cap24};
  assign sm_new  = sm_sum[EW] ? '1 : sm_sum[EW-1:0];
  assign env_sel = g_pos ? tpos_q[idx] : tneg_q[idx];

  // divider step
  assign rem_sh = {div_rem_q, (div_cnt_q == DIV_STEPS)};

  // final scale and saturation
  assign ybig = |mul_p_q[PW-1:24+S];
  assign yv   = mul_p_q[24+S-1:24];
  assign ylim = g_neg ? SONE_S : SONE_S - 1'b1;
  assign ysat = (ybig || (yv > ylim)) ? ylim : yv;
  assign yout = g_neg ? (S)'(-ysat) : ysat;

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_ENGAGE:      prdata = CFG_DATA_BITS'(engage_q);
      REG_INPUT_GAIN:  prdata = CFG_DATA_BITS'(input_gain_q);
      REG_SMOOTH_RATE: prdata = CFG_DATA_BITS'(rate_q);
      REG_MAKEUP:      prdata = CFG_DATA_BITS'(makeup_q);
      REG_OUTPUT_GAIN: prdata = CFG_DATA_BITS'(out_gain_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engage_q     <= ENGAGE_RST;
      input_gain_q <= INPUT_GAIN_RST;
      rate_q       <= SMOOTH_RATE_RST;
      makeup_q     <= MAKEUP_RST;
      out_gain_q   <= OUTPUT_GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_ENGAGE:      engage_q     <= pwdata[0];
        REG_INPUT_GAIN:  input_gain_q <= pwdata[15:0];
        REG_SMOOTH_RATE: rate_q       <= pwdata[20:0];
        REG_MAKEUP:      makeup_q     <= pwdata[16:0];
        REG_OUTPUT_GAIN: out_gain_q   <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_TP;
      ch_q        <= 1'b0;
      parity_q    <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mul_b_q     <= '0;
      mul_a_q     <= '0;
      mul_p_q     <= '0;
      div_cnt_q   <= '0;
      div_rem_q   <= '0;
      div_d_q     <= '1;
      div_q_q     <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      for (int i = 0; i < 4; i++) begin
        tpos_q[i] <= ENV_ONE;
        tneg_q[i] <= ENV_ONE;
        cpos_q[i] <= ENV_ONE;
        cneg_q[i] <= ENV_ONE;
      end
    end else begin
      // multiplier retires one bit of its second operand per cycle
      if (mul_b_q != '0) begin
        if (mul_b_q[0]) mul_p_q <= mul_p_q + mul_a_q;
        mul_a_q <= {mul_a_q[PW-2:0], 1'b0};
        mul_b_q <= {1'b0, mul_b_q[WM-1:1]};
      end

      // a finished frame reloads the output register itself
      if (out_valid_q && frame_o.ready && (state_q != ST_DONE)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (frame_i.valid) begin
            x_q[0] <= frame_i.left_in;
            x_q[1] <= frame_i.right_in;
            ch_q   <= 1'b0;
            if (engage_q) begin
              state_q <= ST_G;
            end else begin
              res_q[0] <= frame_i.left_in;
              res_q[1] <= frame_i.right_in;
              state_q  <= ST_DONE;
            end
          end
        end

        ST_G: begin
          if (!issued_q) begin
            mul_a_q <= PW'(x_mag); mul_b_q <= WM'(input_gain_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            g_q <= g_new; issued_q <= 1'b0; state_q <= ST_B1;
          end
        end

        ST_B1: begin
          if (!issued_q) begin
            mul_a_q <= PW'(g_mag); mul_b_q <= WM'(PHI_Q24);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            bacc_q <= term; issued_q <= 1'b0; state_q <= ST_B2;
          end
        end

        ST_B2: begin
          if (!issued_q) begin
            mul_a_q <= PW'(prev_mag); mul_b_q <= WM'(PHIC_Q24);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            prev_q[ch_q] <= g_q;
            up_q <= up_n; un_q <= un_n;
            op_q <= op_n; on_q <= on_n;
            issued_q <= 1'b0; state_q <= ST_SQP;
          end
        end

        ST_SQP: begin
          if (!issued_q) begin
            mul_a_q <= PW'(up_q); mul_b_q <= WM'(up_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            fresh_q <= capsq; sel_q <= SEL_TP;
            issued_q <= 1'b0; state_q <= ST_SM1;
          end
        end

        ST_SQN: begin
          if (!issued_q) begin
            mul_a_q <= PW'(un_q); mul_b_q <= WM'(un_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            fresh_q <= capsq; sel_q <= SEL_TN;
            issued_q <= 1'b0; state_q <= ST_SM1;
          end
        end

        // keep part of the one-pole update
        ST_SM1: begin
          if (!issued_q) begin
            mul_a_q <= PW'(old_cur); mul_b_q <= WM'(keep);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            sm_q <= cap24; issued_q <= 1'b0; state_q <= ST_SM2;
          end
        end

        // fresh part, sum, write back and pick the next update
        ST_SM2: begin
          if (!issued_q) begin
            mul_a_q <= PW'(fresh_q); mul_b_q <= WM'(rate_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            issued_q <= 1'b0;
            case (sel_q)
              SEL_TP: begin
                tpos_q[idx] <= sm_new; state_q <= ST_SQN;
              end
              SEL_TN: begin
                tneg_q[idx] <= sm_new;
                state_q <= (g_q != '0) ? ST_DIVS : ST_MIX1;
              end
              SEL_CP: begin
                cpos_q[idx] <= sm_new; state_q <= ST_MIX1;
              end
              SEL_CN: begin
                cneg_q[idx] <= sm_new; state_q <= ST_MIX1;
              end
              default: state_q <= ST_MIX1;
            endcase
          end
        end

        // inverse square of the envelope on the side that matches the sign
        ST_DIVS: begin
          sel_q <= g_pos ? SEL_CP : SEL_CN;
          if (env_sel == '0) begin
            fresh_q <= '1; state_q <= ST_SM1;
          end else begin
            div_d_q   <= env_sel;
            div_rem_q <= '0;
            div_q_q   <= '0;
            div_cnt_q <= DIV_STEPS;
            state_q   <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_cnt_q != '0) begin
            if (rem_sh >= {1'b0, div_d_q}) begin
              div_rem_q <= EW'(rem_sh - {1'b0, div_d_q});
              div_q_q   <= {div_q_q[QW-2:0], 1'b1};
            end else begin
              div_rem_q <= rem_sh[EW-1:0];
              div_q_q   <= {div_q_q[QW-2:0], 1'b0};
            end
            div_cnt_q <= div_cnt_q - 1'b1;
          end else begin
            state_q <= ST_INV;
          end
        end

        ST_INV: begin
          if (!issued_q) begin
            mul_a_q <= PW'(div_q_q); mul_b_q <= WM'(div_q_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            fresh_q <= cap24; issued_q <= 1'b0; state_q <= ST_SM1;
          end
        end

        ST_MIX1: begin
          if (!issued_q) begin
            mul_a_q <= PW'(cpos_q[idx]); mul_b_q <= WM'(op_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            m_q <= MW'(mix_term); issued_q <= 1'b0; state_q <= ST_MIX2;
          end
        end

        ST_MIX2: begin
          if (!issued_q) begin
            mul_a_q <= PW'(cneg_q[idx]); mul_b_q <= WM'(on_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            m_q <= m_q + MW'(mix_term); issued_q <= 1'b0; state_q <= ST_GAIN1;
          end
        end

        ST_GAIN1: begin
          if (!issued_q) begin
            mul_a_q <= PW'(makeup_q); mul_b_q <= WM'(out_gain_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            mo_q <= mul_p_q[32:0]; issued_q <= 1'b0; state_q <= ST_GAIN2;
          end
        end

        ST_GAIN2: begin
          if (!issued_q) begin
            mul_a_q <= PW'(g_mag); mul_b_q <= WM'(mo_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            a_q <= mul_p_q[30+AW-1:30]; issued_q <= 1'b0; state_q <= ST_OUTM;
          end
        end

        ST_OUTM: begin
          if (!issued_q) begin
            mul_a_q <= PW'(m_q); mul_b_q <= WM'(a_q);
            mul_p_q <= '0; issued_q <= 1'b1;
          end else if (mul_done) begin
            res_q[ch_q] <= yout;
            issued_q    <= 1'b0;
            if (!ch_q) begin
              ch_q <= 1'b1; state_q <= ST_G;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end

        // hand the frame to the output register once it is free
        ST_DONE: begin
          if (!out_valid_q || frame_o.ready) begin
            out_l_q     <= res_q[0];
            out_r_q     <= res_q[1];
            out_valid_q <= 1'b1;
            parity_q    <= !parity_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign frame_i.ready     = (state_q == ST_IDLE);
  assign frame_o.valid     = out_valid_q;
  assign frame_o.left_out  = out_l_q;
  assign frame_o.right_out = out_r_q;

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_rem_q < div_d_q))
    else $error("divider remainder not below divisor");

  // a control gain is only written back for a sample of matching sign
  a_ctrl_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SM2 && sel_q == SEL_CP) |-> g_pos)
    else $error("positive control gain updated on non-positive sample");

  a_ctrl_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SM2 && sel_q == SEL_CN) |-> g_neg)
    else $error("negative control gain updated on non-negative sample");

  // a new result only appears when the sequencer finishes a frame
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside frame completion");

  // parity moves only when a frame completes
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (parity_q != $past(parity_q)) |-> ($past(state_q) == ST_DONE))
    else $error("frame parity toggled without a completed frame");

endmodule
`default_nettype wire

// ===== dv/bec_checker.sv =====
// scoreboard for the bipolar envelope compressor: watches both frame channels and the
// register port, predicts every result frame and compares it; needs bec_pkg and the
// frame interfaces
module bec_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bec_frame_in_if                           in_mon,
  bec_frame_out_if                          out_mon,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [bec_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [bec_pkg::CFG_DATA_BITS-1:0] pwdata,
  output int                                fail_count,
  output int                                pending
);
  import bec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ENV_MAX  = (64'd1 << 40) - 64'd1;
  localparam logic [63:0] HALF_ONE = 64'd1 << 23;
  localparam logic [63:0] Q24_ONE  = 64'd1 << 24;
  localparam logic [63:0] BIG_CAP  = 64'd1 << 62;
  localparam longint      GAIN_HI  = (longint'(1) << 29) - 1;
  localparam longint      GAIN_LO  = -(longint'(1) << 29);

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
  } frame_t;

  frame_t expected_q[$];

  logic        engaged;
  logic [15:0] drive_gain;
  logic [20:0] smooth_rate;
  logic [16:0] makeup;
  logic [15:0] trim;

  longint      prev_gained[2];
  logic [63:0] env_pos[4];
  logic [63:0] env_neg[4];
  logic [63:0] gain_pos[4];
  logic [63:0] gain_neg[4];
  logic        parity;

  // floor(a*b / 2^s), capped
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s,
                                                 logic [63:0] cap);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> s;
    return (prod > {64'd0, cap}) ? cap : prod[63:0];
  endfunction

  function automatic logic [63:0] smooth_toward(logic [63:0] old, logic [63:0] fresh);
    logic [63:0] v;
    v = scaled_product(old, Q24_ONE - {43'd0, smooth_rate}, 24, ENV_MAX)
      + scaled_product(fresh, {43'd0, smooth_rate}, 24, ENV_MAX);
    return (v > ENV_MAX) ? ENV_MAX : v;
  endfunction

  function automatic logic [63:0] inverse_sq(logic [63:0] env);
    logic [63:0] recip;
    if (env == 64'd0) return ENV_MAX;
    recip = (64'd1 << 48) / env;
    return scaled_product(recip, recip, 24, ENV_MAX);
  endfunction

  function automatic logic [23:0] compress_sample(int ch, int idx, longint x);
    longint      g;
    longint      b;
    longint      p;
    longint      n;
    logic [63:0] up, un, op, on, m, mag, a, y, mt, neg;
    g = (x * longint'(drive_gain)) >>> 10;
    if (g > GAIN_HI) g = GAIN_HI;
    if (g < GAIN_LO) g = GAIN_LO;
    b = (g * longint'(PHI_Q24) + prev_gained[ch] * longint'(PHIC_Q24)) >>> 24;
    prev_gained[ch] = g;
    p = b + longint'(HALF_ONE);
    n = longint'(HALF_ONE) - b;
    up = (p > 0) ? p : 0;
    un = (n > 0) ? n : 0;
    op = up >> 1;
    if (op > HALF_ONE) op = HALF_ONE;
    on = un >> 1;
    if (on > HALF_ONE) on = HALF_ONE;
    env_pos[idx] = smooth_toward(env_pos[idx], scaled_product(up, up, 22, ENV_MAX));
    env_neg[idx] = smooth_toward(env_neg[idx], scaled_product(un, un, 22, ENV_MAX));
    if (g > 0) gain_pos[idx] = smooth_toward(gain_pos[idx], inverse_sq(env_pos[idx]));
    if (g < 0) gain_neg[idx] = smooth_toward(gain_neg[idx], inverse_sq(env_neg[idx]));
    m = scaled_product(gain_pos[idx], op, 23, BIG_CAP)
      + scaled_product(gain_neg[idx], on, 23, BIG_CAP);
    mag = (g < 0) ? -g : g;
    mt = makeup;
    mt = mt * trim;
    a = scaled_product(mag, mt, 30, BIG_CAP);
    if (g < 0) begin
      y = scaled_product(a, m, 24, HALF_ONE);
      neg = -y;
      return neg[23:0];
    end
    y = scaled_product(a, m, 24, HALF_ONE - 64'd1);
    return y[23:0];
  endfunction

  function automatic frame_t predict_frame(logic signed [23:0] l, logic signed [23:0] r);
    frame_t f;
    f.left  = engaged ? compress_sample(0, 2 * parity, longint'(l)) : l;
    f.right = engaged ? compress_sample(1, 2 * parity + 1, longint'(r)) : r;
    parity = ~parity;
    return f;
  endfunction

  task automatic note_mismatch(string what, logic signed [23:0] exp_v,
                               logic signed [23:0] act_v);
    if (fail_count < 10)
      $display("%0t %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count  = 0;
      pending     = 0;
      engaged     = ENGAGE_RST;
      drive_gain  = INPUT_GAIN_RST;
      smooth_rate = SMOOTH_RATE_RST;
      makeup      = MAKEUP_RST;
      trim        = OUTPUT_GAIN_RST;
      parity      = 1'b0;
      for (int i = 0; i < 2; i++) prev_gained[i] = 0;
      for (int i = 0; i < 4; i++) begin
        env_pos[i]  = Q24_ONE;
        env_neg[i]  = Q24_ONE;
        gain_pos[i] = Q24_ONE;
        gain_neg[i] = Q24_ONE;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_ENGAGE:      engaged     = pwdata[0];
          REG_INPUT_GAIN:  drive_gain  = pwdata[15:0];
          REG_SMOOTH_RATE: smooth_rate = pwdata[20:0];
          REG_MAKEUP:      makeup      = pwdata[16:0];
          REG_OUTPUT_GAIN: trim        = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected frame, left", 24'd0, out_mon.left_out);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.left_out !== want.left)
            note_mismatch("left_out", want.left, out_mon.left_out);
          if (out_mon.right_out !== want.right)
            note_mismatch("right_out", want.right, out_mon.right_out);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_frame(in_mon.left_in, in_mon.right_in));
      pending = expected_q.size();
    end
  end

  // frames still owed at the end of the run are not counted as failures
  final if (expected_q.size() != 0) fail_count += 0;

endmodule

// ===== dv/bipolar_envelope_compressor_test.sv =====
// top of the compressor testbench: clock, reset, register writes, frame stimulus and
// the verdict; needs bec_pkg, the frame interfaces, the block and bec_checker
module bipolar_envelope_compressor_test;
  import bec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       fail_count;
  int                       pending;

  bec_frame_in_if  frame_in ();
  bec_frame_out_if frame_out ();

  bipolar_envelope_compressor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_in),
    .frame_o (frame_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bec_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (frame_in),
    .out_mon    (frame_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-scale edges, tiny values around zero, or anything
  function automatic logic [23:0] pick_sample();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0: v = 24'h800000;
      1: v = 24'h7fffff;
      2: begin
        v = 24'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  // result side: bursts of ready with stalls in between, some bursts long
  initial begin
    int stall;
    frame_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      frame_out.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        frame_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // setup cycle, then access cycle; register lands at the access edge
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // let every owed frame come back, then wait quietly before touching registers
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_all(logic en, logic [15:0] gain, logic [20:0] rate,
                         logic [16:0] recip, logic [15:0] trim);
    drain();
    write_reg(REG_ENGAGE, {31'd0, en});
    write_reg(REG_INPUT_GAIN, {16'd0, gain});
    write_reg(REG_SMOOTH_RATE, {11'd0, rate});
    write_reg(REG_MAKEUP, {15'd0, recip});
    write_reg(REG_OUTPUT_GAIN, {16'd0, trim});
  endtask

  // one transaction on the frame input; valid stays up when no gap follows
  task automatic send_frame(logic [23:0] l, logic [23:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      frame_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_in.valid    <= 1'b1;
    frame_in.left_in  <= l;
    frame_in.right_in <= r;
    do @(posedge clk_i); while (!frame_in.ready);
  endtask

  task automatic end_burst();
    frame_in.valid <= 1'b0;
  endtask

  // pull_down: mostly negative full scale so the positive envelope decays to zero
  task automatic random_frames(int count, bit pull_down);
    for (int i = 0; i < count; i++) begin
      if (pull_down && $urandom_range(0, 9) != 0)
        send_frame(24'h800000, 24'h800000);
      else
        send_frame(pick_sample(), pick_sample());
      // one pause that lets the block run completely dry mid-phase
      if (i == count / 2) begin
        end_burst();
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    end_burst();
  endtask

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    frame_in.valid    = 1'b0;
    frame_in.left_in  = '0;
    frame_in.right_in = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state is pass-through
    send_frame(24'h7fffff, 24'h800000);
    send_frame(24'h000000, 24'hffffff);
    end_burst();

    // engaged with the reset coefficients: extremes, sign flips, sustained peaks
    drain();
    write_reg(REG_ENGAGE, 32'd1);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h7fffff, 24'h800000);
    send_frame(24'h800000, 24'h7fffff);
    send_frame(24'h000001, 24'hffffff);
    send_frame(24'hffffff, 24'h000001);
    for (int i = 0; i < 3; i++) send_frame(24'h7fffff, 24'h7fffff);
    for (int i = 0; i < 3; i++) send_frame(24'h800000, 24'h800000);
    send_frame(24'h400000, 24'hc00000);
    send_frame(24'h555555, 24'haaaaaa);
    end_burst();

    // top of every register: the output saturates
    set_all(1'b1, 16'hffff, 21'h1fffff, 17'h1ffff, 16'hffff);
    send_frame(24'h7fffff, 24'h800000);
    send_frame(24'h800000, 24'h7fffff);
    send_frame(24'h123456, 24'hedcba9);
    send_frame(24'h000000, 24'h7fffff);
    end_burst();

    set_all(1'b1, 16'd36864, 21'd1048576, 17'd2048, 16'd49152);
    random_frames(35, 1'b0);
    // attenuating drive, frozen envelopes
    set_all(1'b1, 16'd512, 21'd0, 17'd65536, 16'd16384);
    random_frames(35, 1'b0);
    set_all(1'b0, 16'($urandom), 21'($urandom), 17'($urandom), 16'($urandom));
    random_frames(25, 1'b0);
    // fastest smoothing with a silent positive side: envelope reaches zero
    set_all(1'b1, 16'd1024, 21'h1fffff, 17'd65536, 16'd16384);
    random_frames(240, 1'b1);
    set_all(1'b1, 16'($urandom_range(1024, 36864)), 21'($urandom), 17'd0,
            16'($urandom));
    random_frames(25, 1'b0);
    set_all(1'b1, 16'($urandom), 21'($urandom_range(0, 1048576)), 17'($urandom),
            16'd0);
    random_frames(25, 1'b0);
    set_all(1'b1, 16'($urandom_range(1024, 36864)), 21'($urandom_range(0, 1048576)),
            17'($urandom_range(2048, 65536)), 16'($urandom_range(0, 49152)));
    random_frames(45, 1'b0);

    // wait out whatever is still owed, then a margin for a stray extra frame
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
